>>> rtl/interleaved_frame_deframer_top_assert.svh
// Assertion macros used by the deframer RTL (ifd_parser).
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef INTERLEAVED_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define INTERLEAVED_FRAME_DEFRAMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IFD_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication
`define IFD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define IFD_ASSERT_NOW(lbl, pre, post, msg)
`define IFD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/ifd_pkg.sv
// Shared types and constants for the interleaved frame deframer.
// No dependencies.
package ifd_pkg;

	localparam logic [7:0] DOLLAR_BYTE = 8'h24;
	localparam logic [7:0] MARK_MASK   = 8'hC0;
	localparam logic [7:0] MARK_VALUE  = 8'h80;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHAN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHAN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN   = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SKIPPED = 1'b1;

	typedef struct packed {
		logic [63:0] chan_low;
		logic [63:0] chan_high;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_channel;
		logic       last_of_frame;
	} res_t;

endpackage

>>> rtl/ifd_cfg_regs.sv
// Configuration registers of the deframer: channel enable masks, max payload.
// Depends on ifd_pkg.
module ifd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ifd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                 cfg_data,
	output ifd_pkg::cfg_t               cfg
);
	import ifd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_low    <= '0;
			cfg_q.chan_high   <= '0;
			cfg_q.max_payload <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_CHAN_LOW:  cfg_q.chan_low    <= cfg_data;
				CFG_IDX_CHAN_HIGH: cfg_q.chan_high   <= cfg_data;
				CFG_IDX_MAX_LEN:   cfg_q.max_payload <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/ifd_in_stage.sv
// Input register stage: one byte beat held until the parser takes it.
// Depends on nothing.
module ifd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       advance,
	output logic       byte_valid_s1,
	output logic [7:0] byte_s1
);
	logic take;

	assign s_tready = !byte_valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else begin
			byte_valid_s1 <= take || (byte_valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
		end
	end
endmodule

>>> rtl/ifd_parser.sv
// Frame parser: header tracking, header check with rescan, length count.
// Depends on ifd_pkg and the assertion macro header.
`include "interleaved_frame_deframer_top_assert.svh"
module ifd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  ifd_pkg::cfg_t cfg,
	input  logic          step,
	input  logic [7:0]    in_byte,
	output ifd_pkg::res_t res
);
	import ifd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_CHAN  = 3'd1,
		PH_LENH  = 3'd2,
		PH_LENL  = 3'd3,
		PH_FIRST = 3'd4,
		PH_BODY  = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  chan_q, chan_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] left_q, left_d;
	logic        skip_q, skip_d;

	logic [15:0] len;
	logic [15:0] left_dec;
	logic [15:0] first_left;
	logic        chan_en;
	logic        hdr_bad;
	logic        oversize;

	assign len        = {len_hi_q, len_lo_q};
	assign first_left = len - 16'd1;
	assign left_dec   = left_q - 16'd1;
	assign oversize   = len > cfg.max_payload;
	assign hdr_bad    = !chan_en || ((in_byte & MARK_MASK) != MARK_VALUE);

	// channels 128 and up are never enabled
	always_comb begin
		if (chan_q[7]) begin
			chan_en = 1'b0;
		end else if (chan_q[6]) begin
			chan_en = cfg.chan_high[chan_q[5:0]];
		end else begin
			chan_en = cfg.chan_low[chan_q[5:0]];
		end
	end

	always_comb begin
		phase_d  = phase_q;
		chan_d   = chan_q;
		len_hi_d = len_hi_q;
		len_lo_d = len_lo_q;
		left_d   = left_q;
		skip_d   = skip_q;
		res.valid         = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.payload_byte  = in_byte;
		res.frame_channel = chan_q;
		res.last_of_frame = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (in_byte == DOLLAR_BYTE) begin
					phase_d = PH_CHAN;
				end
			end
			PH_CHAN: begin
				chan_d  = in_byte;
				phase_d = PH_LENH;
			end
			PH_LENH: begin
				len_hi_d = in_byte;
				phase_d  = PH_LENL;
			end
			PH_LENL: begin
				len_lo_d = in_byte;
				// zero length frame is dropped
				phase_d  = ({len_hi_q, in_byte} == 16'd0) ? PH_HUNT : PH_FIRST;
			end
			PH_FIRST: begin
				if (hdr_bad) begin
					// drop '$' and channel, rescan the remaining held bytes
					phase_d = PH_HUNT;
					if (len_hi_q == DOLLAR_BYTE) begin
						chan_d   = len_lo_q;
						len_hi_d = in_byte;
						phase_d  = PH_LENL;
					end else if (len_lo_q == DOLLAR_BYTE) begin
						chan_d  = in_byte;
						phase_d = PH_LENH;
					end else if (in_byte == DOLLAR_BYTE) begin
						phase_d = PH_CHAN;
					end
				end else begin
					res.valid         = !oversize || (first_left == 16'd0);
					res.kind          = oversize ? KIND_SKIPPED : KIND_PAYLOAD;
					res.payload_byte  = oversize ? 8'd0 : in_byte;
					res.last_of_frame = (first_left == 16'd0);
					if (first_left == 16'd0) begin
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_BODY;
						left_d  = first_left;
						skip_d  = oversize;
					end
				end
			end
			PH_BODY: begin
				if (left_q == 16'd0) begin
					phase_d = PH_HUNT;
					skip_d  = 1'b0;
				end else begin
					res.valid         = !skip_q || (left_dec == 16'd0);
					res.kind          = skip_q ? KIND_SKIPPED : KIND_PAYLOAD;
					res.payload_byte  = skip_q ? 8'd0 : in_byte;
					res.last_of_frame = (left_dec == 16'd0);
					left_d            = left_dec;
					if (left_dec == 16'd0) begin
						phase_d = PH_HUNT;
						skip_d  = 1'b0;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
				left_d  = 16'd0;
				skip_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			left_q  <= 16'd0;
			skip_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			skip_q  <= skip_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			chan_q   <= chan_d;
			len_hi_q <= len_hi_d;
			len_lo_q <= len_lo_d;
		end
	end

	`IFD_ASSERT_NOW(a_skip_in_body, skip_q, phase_q == PH_BODY, "skip flag outside payload")
	`IFD_ASSERT_NOW(a_count_only_in_body, phase_q != PH_BODY, left_q == 16'd0,
		"byte count nonzero outside payload")
	`IFD_ASSERT_NEXT(a_last_ends_frame, step && res.valid && res.last_of_frame,
		phase_q == PH_HUNT && !skip_q, "frame end did not return to hunting")
endmodule

>>> rtl/ifd_out_reg.sv
// Result register: holds one result beat until the sink takes it.
// Depends on ifd_pkg.
module ifd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ifd_pkg::res_t res,
	output logic          out_free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic          m_tuser,
	output logic          m_tlast
);
	import ifd_pkg::*;

	logic        kind_q;
	logic [7:0]  byte_q;
	logic [7:0]  chan_q;
	logic        last_q;
	logic        valid_q;

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= res.kind;
			byte_q <= res.payload_byte;
			chan_q <= res.frame_channel;
			last_q <= res.last_of_frame;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {chan_q, byte_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
endmodule

>>> rtl/interleaved_frame_deframer_top.sv
// Interleaved frame deframer, top level. Takes a byte stream of '$'-framed
// frames (channel byte, 16-bit big-endian length, payload) and delivers each
// payload byte tagged with its channel; oversize frames are swallowed and
// reported by one skip beat on their last byte. Throughput is one byte per
// clock while the sink does not stall: header checks and the length count
// are combinational logic between the input register and the result
// register. Bytes outside frames, header bytes, rejected headers and
// zero-length frames give no output beat.
// Depends on ifd_pkg, ifd_cfg_regs, ifd_in_stage, ifd_parser, ifd_out_reg.
module interleaved_frame_deframer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write port; index 0 chan mask low, 1 chan mask high, 2 max payload
	input  logic                          cfg_we,
	input  logic [ifd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] data_byte
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // [7:0] payload_byte, [15:8] frame_channel
	output logic                          m_tuser,  // [0] kind: 0 payload, 1 oversize skipped
	output logic                          m_tlast   // last_of_frame
);
	import ifd_pkg::*;

	cfg_t       cfg;
	res_t       res;
	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;

	// The held byte moves into the parser only when the result register can
	// take whatever it produces; beats with no result move under the same rule.
	assign advance = byte_valid_s1 && out_free;

	ifd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ifd_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.advance       (advance),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1)
	);

	ifd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (advance),
		.in_byte (byte_s1),
		.res     (res)
	);

	ifd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res.valid),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);
endmodule
